FILE: hw/rtl/gwai_pkg.sv
package gwai_pkg;

   localparam int unsigned DEPTH_DEFAULT = 250;

   localparam int unsigned CMD_W          = 2;
   localparam int unsigned TIME_W         = 32;
   localparam int unsigned RATE_W         = 16;
   localparam int unsigned ANGLE_W        = 48;
   localparam int unsigned MIN_INTERVAL_W = 16;
   localparam int unsigned CSR_INDEX_W    = 1;
   localparam int unsigned CSR_DATA_W     = 32;
   localparam int unsigned ENTRY_W        = RATE_W + TIME_W;

   localparam logic [MIN_INTERVAL_W-1:0] MIN_INTERVAL_RESET = MIN_INTERVAL_W'(25);
   localparam logic [TIME_W-1:0]         WINDOW_RESET       = TIME_W'(5000);

   localparam logic [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
   localparam logic [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

   typedef enum logic [CMD_W-1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_QUERY  = 2'd1,
      CMD_CLEAR  = 2'd2
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIN_INTERVAL = 1'b0,
      CSR_WINDOW       = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic item_load;
      logic zero_step;
      logic read_step;
      logic result_load;
   } ctl_type;

   typedef struct packed {
      logic count_last;
      logic pipe_busy;
      logic result_free;
   } stat_type;

endpackage

FILE: hw/rtl/gwai_if.sv
interface gwai_req_if import gwai_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic [TIME_W-1:0]        now_ms;
   logic signed [RATE_W-1:0] gyro_rate;

   modport source (output valid, command, now_ms, gyro_rate, input ready);
   modport sink (input valid, command, now_ms, gyro_rate, output ready);
endinterface

interface gwai_rsp_if import gwai_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      accepted;
   logic signed [ANGLE_W-1:0] angle_sum;

   modport source (output valid, accepted, angle_sum, input ready);
   modport sink (input valid, accepted, angle_sum, output ready);
endinterface

FILE: hw/rtl/gwai_ram.sv
module gwai_ram import gwai_pkg::*; #(
   parameter int unsigned WIDTH = ENTRY_W,
   parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/gwai_ctrl.sv
module gwai_ctrl import gwai_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [CMD_W-1:0] req_command,
   output logic             req_ready,
   input  stat_type         stat,
   output ctl_type          ctl
);

   typedef enum logic [5:0] {
      ST_WIPE    = 6'b000001,
      ST_IDLE    = 6'b000010,
      ST_CLEAR   = 6'b000100,
      ST_QUERY   = 6'b001000,
      ST_DRAIN   = 6'b010000,
      ST_DELIVER = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_WIPE: begin
            ctl.zero_step = 1'b1;
            if (stat.count_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               ctl.item_load = 1'b1;
               case (cmd_type'(req_command))
                  CMD_QUERY: state_in = ST_QUERY;
                  CMD_CLEAR: state_in = ST_CLEAR;
                  default:   state_in = ST_DELIVER;
               endcase
            end
         end
         ST_CLEAR: begin
            ctl.zero_step = 1'b1;
            if (stat.count_last) begin
               state_in = ST_DELIVER;
            end
         end
         ST_QUERY: begin
            ctl.read_step = 1'b1;
            if (stat.count_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (stat.result_free) begin
               ctl.result_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_WIPE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WIPE;
      end else begin
         state_ff <= state_in;
      end
   end

   // pair pipeline must be empty before the sum is handed out
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DELIVER) |-> !stat.pipe_busy)
      else $error("result taken while pair pipeline still busy");

endmodule

FILE: hw/rtl/gwai_dp.sv
module gwai_dp import gwai_pkg::*; #(
   parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ctl_type                   ctl,
   output stat_type                  stat,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_write_data,
   input  logic [CMD_W-1:0]          item_command,
   input  logic [TIME_W-1:0]         item_now_ms,
   input  logic signed [RATE_W-1:0]  item_gyro_rate,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic                      rsp_accepted,
   output logic signed [ANGLE_W-1:0] rsp_angle_sum
);

   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam int unsigned RSUM_W = RATE_W + 1;
   localparam int unsigned PROD_W = RSUM_W + TIME_W;
   localparam int unsigned ACC_W  = PROD_W + ADDR_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   logic [MIN_INTERVAL_W-1:0] min_interval_ff, min_interval_in;
   logic [TIME_W-1:0]         window_ff, window_in;
   cmd_type                   cmd_ff, cmd_in;
   logic [TIME_W-1:0]         now_ff, now_in;
   logic signed [RATE_W-1:0]  rate_ff, rate_in;
   logic [TIME_W-1:0]         thr_ff, thr_in;
   logic [ADDR_W-1:0]         wp_ff, wp_in;
   logic [TIME_W-1:0]         last_ff, last_in;
   logic                      have_ff, have_in;
   logic [ADDR_W-1:0]         addr_ff, addr_in;
   logic [ADDR_W-1:0]         cnt_ff, cnt_in;
   logic                      rd_pend_ff, rd_pend_in;
   logic                      first_ff, first_in;
   logic [ENTRY_W-1:0]        prev_ff, prev_in;
   logic                      pair_vld_ff, pair_vld_in;
   logic signed [RSUM_W-1:0]  rsum_ff, rsum_in;
   logic [TIME_W-1:0]         dt_ff, dt_in;
   logic                      prod_vld_ff, prod_vld_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      accepted_ff, accepted_in;
   logic [ANGLE_W-1:0]        angle_ff, angle_in;

   logic [ENTRY_W-1:0] rd_data;
   logic [ENTRY_W-1:0] wr_data;
   logic [ADDR_W-1:0]  wr_addr;
   logic               wr_en;

   logic [TIME_W-1:0]        ta, tb, earliest;
   logic signed [RATE_W-1:0] ra, rb;
   logic                     keep, take, commit, in_range;
   logic [ANGLE_W-1:0]       sat;

   gwai_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (ctl.read_step),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // sample gate
   assign earliest = last_ff + TIME_W'(min_interval_ff);
   assign take     = !have_ff || (now_ff >= earliest);
   assign commit   = ctl.result_load && (cmd_ff == CMD_SAMPLE) && take;

   assign wr_en   = ctl.zero_step || commit;
   assign wr_addr = ctl.zero_step ? addr_ff : wp_ff;
   assign wr_data = ctl.zero_step ? '0 : {rate_ff, now_ff};

   // pair check
   assign ta   = prev_ff[TIME_W-1:0];
   assign tb   = rd_data[TIME_W-1:0];
   assign ra   = prev_ff[ENTRY_W-1 -: RATE_W];
   assign rb   = rd_data[ENTRY_W-1 -: RATE_W];
   assign keep = (ta >= thr_ff) && (tb > ta);

   // saturate to the result width
   assign in_range = (&acc_ff[ACC_W-1:ANGLE_W-1]) || !(|acc_ff[ACC_W-1:ANGLE_W-1]);
   assign sat      = in_range ? acc_ff[ANGLE_W-1:0] :
                     (acc_ff[ACC_W-1] ? ANGLE_MIN : ANGLE_MAX);

   always_comb begin
      min_interval_in = min_interval_ff;
      window_in       = window_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_INTERVAL: min_interval_in = csr_write_data[MIN_INTERVAL_W-1:0];
            CSR_WINDOW:       window_in       = csr_write_data[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cmd_in   = cmd_ff;
      now_in   = now_ff;
      rate_in  = rate_ff;
      thr_in   = thr_ff;
      addr_in  = addr_ff;
      cnt_in   = cnt_ff;
      first_in = first_ff;
      acc_in   = acc_ff;
      if (ctl.item_load) begin
         cmd_in   = cmd_type'(item_command);
         now_in   = item_now_ms;
         rate_in  = item_gyro_rate;
         thr_in   = item_now_ms - window_ff;
         addr_in  = (cmd_type'(item_command) == CMD_QUERY) ? wp_ff : '0;
         cnt_in   = '0;
         first_in = 1'b1;
         acc_in   = '0;
      end else begin
         if (ctl.zero_step || ctl.read_step) begin
            addr_in = (addr_ff == LAST_ADDR) ? '0 : addr_ff + 1'b1;
            cnt_in  = cnt_ff + 1'b1;
         end
         if (rd_pend_ff) begin
            first_in = 1'b0;
         end
         if (prod_vld_ff) begin
            acc_in = acc_ff + ACC_W'(prod_ff);
         end
      end
   end

   always_comb begin
      rd_pend_in  = ctl.read_step;
      prev_in     = rd_pend_ff ? rd_data : prev_ff;
      pair_vld_in = rd_pend_ff && !first_ff;
      rsum_in     = keep ? ({ra[RATE_W-1], ra} + {rb[RATE_W-1], rb}) : '0;
      dt_in       = tb - ta;
      prod_vld_in = pair_vld_ff;
      prod_in     = PROD_W'(rsum_ff) * PROD_W'($signed({1'b0, dt_ff}));
   end

   always_comb begin
      wp_in   = wp_ff;
      last_in = last_ff;
      have_in = have_ff;
      if (commit) begin
         wp_in   = (wp_ff == LAST_ADDR) ? '0 : wp_ff + 1'b1;
         last_in = now_ff;
         have_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = ctl.result_load || (rsp_valid_ff && !rsp_ready);
      accepted_in  = accepted_ff;
      angle_in     = angle_ff;
      if (ctl.result_load) begin
         accepted_in = commit;
         angle_in    = (cmd_ff == CMD_QUERY) ? sat : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_interval_ff <= MIN_INTERVAL_RESET;
         window_ff       <= WINDOW_RESET;
         wp_ff           <= '0;
         last_ff         <= '0;
         have_ff         <= 1'b0;
         addr_ff         <= '0;
         cnt_ff          <= '0;
         first_ff        <= 1'b1;
         rd_pend_ff      <= 1'b0;
         pair_vld_ff     <= 1'b0;
         prod_vld_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         min_interval_ff <= min_interval_in;
         window_ff       <= window_in;
         wp_ff           <= wp_in;
         last_ff         <= last_in;
         have_ff         <= have_in;
         addr_ff         <= addr_in;
         cnt_ff          <= cnt_in;
         first_ff        <= first_in;
         rd_pend_ff      <= rd_pend_in;
         pair_vld_ff     <= pair_vld_in;
         prod_vld_ff     <= prod_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      now_ff      <= now_in;
      rate_ff     <= rate_in;
      thr_ff      <= thr_in;
      prev_ff     <= prev_in;
      rsum_ff     <= rsum_in;
      dt_ff       <= dt_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      accepted_ff <= accepted_in;
      angle_ff    <= angle_in;
   end

   assign stat.count_last  = (cnt_ff == LAST_ADDR);
   assign stat.pipe_busy   = rd_pend_ff || pair_vld_ff || prod_vld_ff;
   assign stat.result_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_accepted  = accepted_ff;
   assign rsp_angle_sum = angle_ff;

   assert property (@(posedge clock) disable iff (reset)
      ctl.result_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before it was taken");

   assert property (@(posedge clock) disable iff (reset)
      !ctl.result_load |=> $stable(wp_ff))
      else $error("write pointer moved outside a sample commit");

endmodule

FILE: hw/rtl/gyro_window_angle_integrator.sv
// Windowed gyro angle integrator. Items arrive one at a time on req_chan: command 0 offers a
// sample (stored when the minimum interval has passed since the last stored one), command 1
// sums (r1 + r2) * dt over the ring pairs inside the window, command 2 zeroes the ring.
// Every item gives exactly one item on rsp_chan. A sample or an unused command goes from accept
// through a deliver state, which waits while the output register still holds an untaken result,
// until req_chan.ready returns; a query walks the ring RAM one entry per cycle through the
// single read port, then a short multiply and accumulate pipeline; a clear makes one RAM
// write per entry. After reset the ring is swept to zero, and no item is accepted during
// the sweep; configuration writes are taken at any time. A finished result sits in an output
// register, so the next item is accepted while it waits to be taken.
module gyro_window_angle_integrator import gwai_pkg::*; #(
   parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   gwai_req_if.sink               req_chan,
   gwai_rsp_if.source             rsp_chan,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   ctl_type  ctl;
   stat_type stat;

   gwai_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_command (req_chan.command),
      .req_ready   (req_chan.ready),
      .stat        (stat),
      .ctl         (ctl)
   );

   gwai_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .stat             (stat),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .item_command     (req_chan.command),
      .item_now_ms      (req_chan.now_ms),
      .item_gyro_rate   (req_chan.gyro_rate),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_accepted     (rsp_chan.accepted),
      .rsp_angle_sum    (rsp_chan.angle_sum)
   );

endmodule
